FILE: rtl/clt_pkg.sv
// Shared types and constants for the command line tokenizer.
`timescale 1ns / 1ps

package clt_pkg;

    localparam int MAX_ARGS_DEF     = 8;
    localparam int MAX_WORD_LEN_DEF = 32;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam int TOK_OUT_W = 4;
    localparam int POS_OUT_W = 5;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TOO_MANY = 2'd1,
        ERR_TOO_LONG = 2'd2
    } t_err;

    typedef struct packed {
        logic                 store_valid;
        logic [TOK_OUT_W-1:0] token_index;
        logic [POS_OUT_W-1:0] char_position;
        logic [7:0]           char_out;
        logic                 line_done;
        logic [TOK_OUT_W-1:0] arg_count;
        t_err                 error_code;
    } t_result;

endpackage

FILE: rtl/clt_tokenizer.sv
// Tokenizer state registers and the per-character step logic.
`timescale 1ns / 1ps

module clt_tokenizer
    import clt_pkg::*;
#(
    parameter int MAX_ARGS     = MAX_ARGS_DEF,
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_has_result,
    output t_result    o_result
);

    localparam int TOK_W = $clog2(MAX_ARGS + 2);
    localparam int POS_W = $clog2(MAX_WORD_LEN + 1);

    logic             r_cap, n_cap;
    logic             r_quo, n_quo;
    logic [TOK_W-1:0] r_tok, n_tok;
    logic [POS_W-1:0] r_pos, n_pos;
    t_err             r_err, n_err;

    logic             want;
    logic             store;
    logic             done;
    logic [TOK_W-1:0] fin_tok;
    logic [TOK_W-1:0] cnt;
    logic [TOK_W-1:0] s_tok;
    logic [POS_W-1:0] s_pos;
    logic [TOK_W+TOK_OUT_W-1:0] tok_ext;
    logic [TOK_W+TOK_OUT_W-1:0] cnt_ext;
    logic [POS_W+POS_OUT_W-1:0] pos_ext;

    always_comb begin
        n_cap   = r_cap;
        n_quo   = r_quo;
        n_tok   = r_tok;
        n_pos   = r_pos;
        n_err   = r_err;
        want    = 1'b0;
        store   = 1'b0;
        done    = 1'b0;
        s_tok   = '0;
        s_pos   = '0;
        fin_tok = '0;
        cnt     = '0;

        if (i_ch == CH_NEWLINE) begin
            done = 1'b1;
        end else if (r_err == ERR_NONE) begin
            if (r_cap) begin
                if (i_ch == (r_quo ? CH_QUOTE : CH_SPACE)) begin
                    n_cap = 1'b0;
                    n_quo = 1'b0;
                    n_pos = '0;
                    n_tok = r_tok + 1'b1;
                    if (n_tok > TOK_W'(MAX_ARGS)) begin
                        n_err = ERR_TOO_MANY;
                    end
                end else begin
                    want = 1'b1;
                end
            end else if (i_ch == CH_QUOTE) begin
                n_cap = 1'b1;
                n_quo = 1'b1;
                n_pos = '0;
            end else if (i_ch != CH_SPACE) begin
                n_cap = 1'b1;
                n_quo = 1'b0;
                n_pos = '0;
                want  = 1'b1;
            end
            if (want) begin
                if (n_pos >= POS_W'(MAX_WORD_LEN)) begin
                    n_err = ERR_TOO_LONG;
                end else begin
                    store = 1'b1;
                    s_tok = r_tok;
                    s_pos = n_pos;
                    n_pos = n_pos + 1'b1;
                end
            end
        end

        if (i_last) begin
            done = 1'b1;
        end

        if (done) begin
            // a word still open counts unless an error cut the line short
            fin_tok = n_tok + TOK_W'(n_cap && (n_err == ERR_NONE));
            cnt     = (fin_tok != '0) ? fin_tok - 1'b1 : '0;
        end
    end

    assign tok_ext = {{TOK_OUT_W{1'b0}}, s_tok};
    assign cnt_ext = {{TOK_OUT_W{1'b0}}, cnt};
    assign pos_ext = {{POS_OUT_W{1'b0}}, s_pos};

    always_comb begin
        o_result               = '0;
        o_result.store_valid   = store;
        o_result.token_index   = tok_ext[TOK_OUT_W-1:0];
        o_result.char_position = pos_ext[POS_OUT_W-1:0];
        o_result.char_out      = store ? i_ch : 8'h00;
        o_result.line_done     = done;
        o_result.arg_count     = cnt_ext[TOK_OUT_W-1:0];
        o_result.error_code    = done ? n_err : ERR_NONE;
    end

    assign o_has_result = store || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 1'b0;
            r_quo <= 1'b0;
            r_tok <= '0;
            r_pos <= '0;
            r_err <= ERR_NONE;
        end else if (i_en) begin
            if (done) begin
                r_cap <= 1'b0;
                r_quo <= 1'b0;
                r_tok <= '0;
                r_pos <= '0;
                r_err <= ERR_NONE;
            end else begin
                r_cap <= n_cap;
                r_quo <= n_quo;
                r_tok <= n_tok;
                r_pos <= n_pos;
                r_err <= n_err;
            end
        end
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_WORD_LEN))
        else $error("position counter past word limit");

    a_tok_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err == ERR_NONE) |-> (r_tok <= TOK_W'(MAX_ARGS)))
        else $error("token counter past limit without error");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && done) |=> (!r_cap && r_tok == '0 && r_err == ERR_NONE))
        else $error("state not cleared after line end");
`endif

endmodule

FILE: rtl/command_line_tokenizer.sv
// Top level: input register, tokenizer step and output register.
//
// Input channel: i_in_valid / o_in_stall with i_ch and i_last; one
// character is accepted at an edge where i_in_valid is high and
// o_in_stall is low. Output channel: o_out_valid / i_out_stall with one
// port per result field; a result is taken when o_out_valid is high
// and i_out_stall is low.
// A character produces a result if it is stored into a token or ends
// the line (newline or i_last); other characters produce none.
// The character goes from the input register through the step logic
// into the result register; o_out_valid rises when the result register
// is loaded with the output of the step logic.
// Throughput: one character per cycle while the receiver does not stall;
// the token state update is a registered loop around the step logic.
// Reset (synchronous, active low) empties both registers and clears the
// tokenizer state. While the receiver stalls, the result is held; an
// empty input register takes one more character, then o_in_stall rises.
`timescale 1ns / 1ps

module command_line_tokenizer
    import clt_pkg::*;
#(
    parameter int MAX_ARGS     = MAX_ARGS_DEF,
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_ch,
    input  logic                 i_last,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_store_valid,
    output logic [TOK_OUT_W-1:0] o_token_index,
    output logic [POS_OUT_W-1:0] o_char_position,
    output logic [7:0]           o_char_out,
    output logic                 o_line_done,
    output logic [TOK_OUT_W-1:0] o_arg_count,
    output logic [1:0]           o_error_code
);

    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_last;
    logic       r_out_valid;
    t_result    r_res;

    logic       advance;
    logic       in_accept;
    logic       step_en;
    logic       has_result;
    t_result    step_res;

    assign advance   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept = i_in_valid && !o_in_stall;
    assign step_en   = r_in_valid && advance;

    clt_tokenizer #(
        .MAX_ARGS     (MAX_ARGS),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_tok (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (step_en),
        .i_ch         (r_ch),
        .i_last       (r_last),
        .o_has_result (has_result),
        .o_result     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_en && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_store_valid   = r_res.store_valid;
    assign o_token_index   = r_res.token_index;
    assign o_char_position = r_res.char_position;
    assign o_char_out      = r_res.char_out;
    assign o_line_done     = r_res.line_done;
    assign o_arg_count     = r_res.arg_count;
    assign o_error_code    = r_res.error_code;

`ifndef SYNTHESIS
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.store_valid || r_res.line_done))
        else $error("result that neither stores nor ends the line");

    a_no_store_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.store_valid) |->
        (r_res.token_index == '0 && r_res.char_position == '0 && r_res.char_out == 8'h00))
        else $error("store fields not zero without a store");

    a_stall_blocks_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !step_en)
        else $error("step taken while the result register is held");
`endif

endmodule
